/* design/cddn_pkg.sv */
`default_nettype none
// ============================================================================
// Civil date converter package
// Shared widths, calendar constants, word types and the cumulative month table
// for the civil date and day number converter.
// ============================================================================
package cddn_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int NUM_W   = 22;
    localparam int DOY_W   = 9;
    localparam int Q100_W  = 8;

    localparam logic [YEAR_W-1:0]  YEAR_MIN = 14'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
    localparam logic [NUM_W-1:0]   NUM_MIN  = 22'd693961;
    localparam logic [NUM_W-1:0]   NUM_MAX  = 22'd3652424;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

    localparam logic [DOY_W-1:0] DAYS_COMMON_YEAR = 9'd365;
    localparam int CENTURY   = 100;
    localparam int QUAD_CENT = 400;
    localparam int CYCLE_DAYS = 146097;

    // Year estimate floor(n * 400 / 146097) by a rounded-up reciprocal.
    localparam int EST_SHIFT   = 40;
    localparam int EST_RECIP_W = 32;
    localparam logic [63:0] EST_RECIP_FULL =
        ((64'd1 << EST_SHIFT) * 64'(QUAD_CENT) + 64'(CYCLE_DAYS - 1)) / 64'(CYCLE_DAYS);
    localparam logic [EST_RECIP_W-1:0] EST_RECIP = EST_RECIP_W'(EST_RECIP_FULL);

    // Division of a year by one hundred by a rounded-up reciprocal.
    localparam int DIV100_SHIFT = 20;
    localparam logic [63:0] DIV100_RECIP_FULL =
        ((64'd1 << DIV100_SHIFT) + 64'(CENTURY - 1)) / 64'(CENTURY);
    localparam logic [YEAR_W-1:0] DIV100_RECIP = YEAR_W'(DIV100_RECIP_FULL);

    typedef enum logic {
        ACT_DATE_TO_NUM = 1'b0,
        ACT_NUM_TO_DATE = 1'b1
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [YEAR_W-1:0]  in_year;
        logic [MONTH_W-1:0] in_month;
        logic [DAY_W-1:0]   in_day;
        logic [NUM_W-1:0]   in_day_number;
    } date_cmd_t;

    typedef struct packed {
        logic [NUM_W-1:0]   out_day_number;
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [DAY_W-1:0]   out_day;
        logic               range_error;
    } date_result_t;

    typedef struct packed {
        logic [NUM_W-1:0] base;
        logic             leap_prev;
        logic             leap_cur;
        logic             leap_next;
    } year_info_t;

    function automatic logic [DOY_W-1:0] cum_days(input logic leap,
                                                  input logic [MONTH_W-1:0] idx);
        logic [DOY_W-1:0] common;
        logic [DOY_W-1:0] extra;
        begin
            unique case (idx)
                4'd0:    common = 9'd0;
                4'd1:    common = 9'd31;
                4'd2:    common = 9'd59;
                4'd3:    common = 9'd90;
                4'd4:    common = 9'd120;
                4'd5:    common = 9'd151;
                4'd6:    common = 9'd181;
                4'd7:    common = 9'd212;
                4'd8:    common = 9'd243;
                4'd9:    common = 9'd273;
                4'd10:   common = 9'd304;
                4'd11:   common = 9'd334;
                4'd12:   common = 9'd365;
                default: common = 9'd0;
            endcase
            extra = (leap && idx >= 4'd2 && idx <= MONTH_LAST) ? 9'd1 : 9'd0;
            return common + extra;
        end
    endfunction

endpackage
`default_nettype wire

/* design/cddn_year_calc.sv */
`default_nettype none
// ============================================================================
// Year base calculator
// Gives the day number of day zero of a year and the leap flags of that year
// and of its two neighbors.
// ============================================================================
module cddn_year_calc
    import cddn_pkg::*;
(
    input  wire logic [YEAR_W-1:0] year,
    output year_info_t             info
);

    logic [YEAR_W-1:0]   prev_year;
    logic [2*YEAR_W-1:0] q100_prod;
    logic [Q100_W-1:0]   q100;
    logic [6:0]          rem100;
    logic [8:0]          rem400;
    logic [YEAR_W-3:0]   q4;
    logic [Q100_W-3:0]   q400;

    always_comb
    begin
        prev_year = year - 14'd1;
        q100_prod = (2*YEAR_W)'(prev_year) * (2*YEAR_W)'(DIV100_RECIP);
        q100      = q100_prod[DIV100_SHIFT +: Q100_W];
        rem100    = 7'(prev_year - YEAR_W'(q100) * YEAR_W'(CENTURY));
        q4        = prev_year[YEAR_W-1:2];
        q400      = q100[Q100_W-1:2];
        rem400    = 9'(q100[1:0]) * 9'(CENTURY) + 9'(rem100);

        info.base = NUM_W'(year) * NUM_W'(DAYS_COMMON_YEAR) + NUM_W'(q4)
                  - NUM_W'(q100) + NUM_W'(q400);

        // The year before is leap when the previous year itself divides.
        info.leap_prev = (prev_year[1:0] == 2'd0)
                      && (rem100 != 7'd0 || rem400 == 9'd0);
        info.leap_cur  = (prev_year[1:0] == 2'd3)
                      && (rem100 != 7'd99 || rem400 == 9'd399);
        info.leap_next = (prev_year[1:0] == 2'd2)
                      && (rem100 != 7'd98 || rem400 == 9'd398);
    end

endmodule
`default_nettype wire

/* design/civil_date_day_number_converter.sv */
`default_nettype none
// ============================================================================
// Civil date and day number converter
// Converts a Gregorian date to a serial day number or a day number to a date.
// ============================================================================
// A command word on item is taken at each rising edge where start is high and
// busy is low. busy is always low, so a word can be issued in every cycle.
// The action field selects the direction. Dates from 1900-01-01 to 9999-12-31
// (day numbers 693961 to 3652424) are supported; anything else returns a word
// with range_error set and all value fields zero.
// The result word appears on result with done high for exactly one cycle and
// is taken at the edge that ends that cycle. The receiver cannot stall.
// Each word passes through s1_reg, s2_reg and result_reg, and throughput
// is one word per cycle. The first stage holds the year estimate multiply,
// the second the division of the year by one hundred and the year base,
// the third the year correction and the month search over the cumulative
// month table.
// Reset clears all words in flight; no done strobe follows a reset until a
// new word is issued.
// ============================================================================
module civil_date_day_number_converter
    import cddn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire date_cmd_t item,
    output logic           done,
    output date_result_t   result
);

    typedef struct packed {
        date_cmd_t         cmd;
        logic [YEAR_W-1:0] year_est;
    } stage_t;

    logic          s1_valid_reg, s1_valid_next;
    stage_t        s1_reg, s1_next;
    logic          s2_valid_reg, s2_valid_next;
    stage_t        s2_reg, s2_next;
    year_info_t    info_reg, info_next;
    logic          done_reg, done_next;
    date_result_t  result_reg, result_next;

    logic [NUM_W+EST_RECIP_W-1:0] est_prod;
    year_info_t        info_calc;
    logic [NUM_W-1:0]  base_prev;
    logic [NUM_W-1:0]  base_next;
    logic [NUM_W-1:0]  year_base;
    logic [YEAR_W-1:0] year_found;
    logic              year_leap;
    logic [DOY_W-1:0]  doy;
    logic [MONTH_W-1:0] month_found;
    logic [DAY_W-1:0]  day_found;
    logic [DOY_W-1:0]  month_len;
    logic              num_err;
    logic              date_err;

    assign busy = 1'b0;

    always_comb
    begin
        est_prod           = (NUM_W+EST_RECIP_W)'(item.in_day_number)
                           * (NUM_W+EST_RECIP_W)'(EST_RECIP);
        s1_valid_next      = start && !busy;
        s1_next.cmd        = item;
        s1_next.year_est   = (item.action == ACT_NUM_TO_DATE)
                           ? est_prod[EST_SHIFT +: YEAR_W] : item.in_year;
    end

    cddn_year_calc u_year_calc
    (
        .year (s1_reg.year_est),
        .info (info_calc)
    );

    always_comb
    begin
        s2_valid_next = s1_valid_reg;
        s2_next       = s1_reg;
        info_next     = info_calc;
    end

    always_comb
    begin
        base_prev = info_reg.base - NUM_W'(DAYS_COMMON_YEAR) - NUM_W'(info_reg.leap_prev);
        base_next = info_reg.base + NUM_W'(DAYS_COMMON_YEAR) + NUM_W'(info_reg.leap_cur);

        priority if (s2_reg.cmd.in_day_number <= info_reg.base)
        begin
            year_found = s2_reg.year_est - 14'd1;
            year_base  = base_prev;
            year_leap  = info_reg.leap_prev;
        end
        else if (s2_reg.cmd.in_day_number > base_next)
        begin
            year_found = s2_reg.year_est + 14'd1;
            year_base  = base_next;
            year_leap  = info_reg.leap_next;
        end
        else
        begin
            year_found = s2_reg.year_est;
            year_base  = info_reg.base;
            year_leap  = info_reg.leap_cur;
        end

        doy         = DOY_W'(s2_reg.cmd.in_day_number - year_base);
        month_found = MONTH_FIRST;
        for (int i = 1; i < 12; i++)
        begin
            if (cum_days(year_leap, MONTH_W'(i)) < doy)
            begin
                month_found = month_found + 4'd1;
            end
        end
        day_found = DAY_W'(doy - cum_days(year_leap, month_found - 4'd1));

        num_err = (s2_reg.cmd.in_day_number < NUM_MIN)
               || (s2_reg.cmd.in_day_number > NUM_MAX);

        month_len = cum_days(info_reg.leap_cur, s2_reg.cmd.in_month)
                  - cum_days(info_reg.leap_cur, s2_reg.cmd.in_month - 4'd1);
        date_err  = (s2_reg.cmd.in_year < YEAR_MIN) || (s2_reg.cmd.in_year > YEAR_MAX)
                 || (s2_reg.cmd.in_month < MONTH_FIRST) || (s2_reg.cmd.in_month > MONTH_LAST)
                 || (s2_reg.cmd.in_day == 5'd0)
                 || (DOY_W'(s2_reg.cmd.in_day) > month_len);

        done_next = s2_valid_reg;
        if (s2_reg.cmd.action == ACT_NUM_TO_DATE)
        begin
            result_next.out_day_number = s2_reg.cmd.in_day_number;
            result_next.out_year       = year_found;
            result_next.out_month      = month_found;
            result_next.out_day        = day_found;
            result_next.range_error    = num_err;
        end
        else
        begin
            result_next.out_day_number = info_reg.base
                + NUM_W'(cum_days(info_reg.leap_cur, s2_reg.cmd.in_month - 4'd1))
                + NUM_W'(s2_reg.cmd.in_day);
            result_next.out_year       = s2_reg.cmd.in_year;
            result_next.out_month      = s2_reg.cmd.in_month;
            result_next.out_day        = s2_reg.cmd.in_day;
            result_next.range_error    = date_err;
        end

        if (result_next.range_error)
        begin
            result_next.out_day_number = '0;
            result_next.out_year       = '0;
            result_next.out_month      = '0;
            result_next.out_day        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_next)
        begin
            s1_reg <= s1_next;
        end
        if (s2_valid_next)
        begin
            s2_reg   <= s2_next;
            info_reg <= info_next;
        end
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted word yields its result with done high.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted word produced no result after three cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result word without a matching accepted word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.range_error) |->
            (result.out_day_number == '0 && result.out_year == '0
             && result.out_month == '0 && result.out_day == '0))
        else $error("error word carries nonzero value fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.range_error) |->
            (result.out_month >= MONTH_FIRST && result.out_month <= MONTH_LAST
             && result.out_day != '0))
        else $error("month or day of a valid result out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.range_error) |->
            (result.out_day_number >= NUM_MIN && result.out_day_number <= NUM_MAX
             && result.out_year >= YEAR_MIN && result.out_year <= YEAR_MAX))
        else $error("valid result outside the supported span");

endmodule
`default_nettype wire
